// ===== rtl/i2cm_pkg.sv =====
package i2cm_pkg;

  localparam int BYTE_BITS   = 8;
  localparam int HALF_W      = 16;
  localparam int LIMIT_W     = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [HALF_W-1:0]      HALF_PERIOD_RST   = 16'd80;
  localparam logic [LIMIT_W-1:0]     STRETCH_LIMIT_RST = 8'd255;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_STRETCH_LIMIT = 1'b1;

  // Raw command codes on the input channel
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_START,
    OP_STOP,
    OP_WRITE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [BYTE_BITS-1:0] wr_data;
    logic                 rd_ack;
    logic                 sda;
    logic                 scl;
  } item_t;

  typedef struct packed {
    logic [HALF_W-1:0]  half_period;
    logic [LIMIT_W-1:0] stretch_limit;
  } cfg_t;

endpackage

// ===== rtl/i2cm_front.sv =====
module i2cm_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    cmd,
  input  logic [i2cm_pkg::BYTE_BITS-1:0] wr_data,
  input  logic                          rd_ack,
  input  logic                          sda_in,
  input  logic                          scl_in,
  input  logic                          q_full,
  output logic                          push,
  output i2cm_pkg::item_t               push_item
);
  import i2cm_pkg::*;

  op_t op;

  // Unknown codes act as ticks: ignored when idle, a tick when busy
  always_comb begin
    unique case (cmd)
      CMD_START: op = OP_START;
      CMD_STOP:  op = OP_STOP;
      CMD_WRITE: op = OP_WRITE;
      CMD_READ:  op = OP_READ;
      default:   op = OP_TICK;
    endcase
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  assign push_item.op       = op;
  assign push_item.wr_data  = wr_data;
  assign push_item.rd_ack   = rd_ack;
  assign push_item.sda      = sda_in;
  assign push_item.scl      = scl_in;

endmodule

// ===== rtl/i2cm_fifo.sv =====
module i2cm_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  i2cm_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output i2cm_pkg::item_t q_item
);
  import i2cm_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full    = (count == (PTR_W+1)'(DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/i2cm_engine.sv =====
module i2cm_engine #(
  parameter int PAUSE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  i2cm_pkg::cfg_t                 cfg,
  input  logic                           q_valid,
  input  i2cm_pkg::item_t                item,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           sda_low,
  output logic                           scl_low,
  output logic                           busy_res,
  output logic                           done_res,
  output logic                           ack_seen,
  output logic [i2cm_pkg::BYTE_BITS-1:0] read_byte
);
  import i2cm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_STA_STR   = 5'd1,
    PH_STA_SDA   = 5'd2,
    PH_STA_SCL   = 5'd3,
    PH_STO_SETUP = 5'd4,
    PH_STO_STR   = 5'd5,
    PH_STO_SDA   = 5'd6,
    PH_STO_HOLD  = 5'd7,
    PH_WR_SETUP  = 5'd8,
    PH_WR_STR    = 5'd9,
    PH_WR_HIGH   = 5'd10,
    PH_WA_SETUP  = 5'd11,
    PH_WA_STR    = 5'd12,
    PH_WA_HIGH   = 5'd13,
    PH_WA_HOLD   = 5'd14,
    PH_RD_SETUP  = 5'd15,
    PH_RD_STR    = 5'd16,
    PH_RD_HIGH   = 5'd17,
    PH_RA_SETUP  = 5'd18,
    PH_RA_STR    = 5'd19,
    PH_RA_HIGH   = 5'd20,
    PH_RA_HOLD   = 5'd21
  } phase_t;

  typedef enum logic [1:0] {
    WK_NONE,
    WK_PAUSE,
    WK_STRETCH
  } wait_kind_t;

  function automatic wait_kind_t wait_kind(input phase_t p);
    wait_kind_t k;
    case (p) inside
      PH_STA_STR, PH_STO_STR, PH_WR_STR, PH_WA_STR, PH_RD_STR, PH_RA_STR:
        k = WK_STRETCH;
      PH_STA_SDA, PH_STA_SCL, PH_STO_SETUP, PH_STO_SDA, PH_STO_HOLD,
      PH_WR_SETUP, PH_WR_HIGH, PH_WA_SETUP, PH_WA_HIGH, PH_WA_HOLD,
      PH_RD_SETUP, PH_RD_HIGH, PH_RA_SETUP, PH_RA_HIGH, PH_RA_HOLD:
        k = WK_PAUSE;
      default:
        k = WK_NONE;
    endcase
    return k;
  endfunction

  phase_t                 phase, phase_next;
  logic [3:0]             bit_count, bit_count_next;
  logic [BYTE_BITS-1:0]   shift_reg, shift_reg_next;
  logic [PAUSE_BITS-1:0]  pause_count, pause_count_next;
  logic [LIMIT_W-1:0]     stretch_count, stretch_count_next;
  logic                   ack_to_send, ack_to_send_next;
  logic                   ack_flag, ack_flag_next;
  logic                   sda_drive, sda_drive_next;
  logic                   scl_drive, scl_drive_next;
  logic [BYTE_BITS-1:0]   rd_hold, rd_hold_next;

  logic                   fire;
  logic                   done;
  logic                   go;
  logic                   ent_go;
  logic                   ent_done;
  phase_t                 ent;
  logic [3:0]             bc_inc;
  logic [LIMIT_W-1:0]     sc_inc;
  logic [BYTE_BITS-1:0]   sh_shift;
  logic [31:0]            hp_ext;
  logic [PAUSE_BITS-1:0]  hp_trunc;
  logic [PAUSE_BITS-1:0]  pause_load;

  assign fire = q_valid && (!out_valid || out_ready);
  assign pop  = fire;

  // A zero pause length still lasts one tick
  assign hp_ext     = 32'(cfg.half_period);
  assign hp_trunc   = hp_ext[PAUSE_BITS-1:0];
  assign pause_load = (hp_trunc == '0) ? PAUSE_BITS'(1) : hp_trunc;

  assign bc_inc   = bit_count + 4'd1;
  assign sc_inc   = stretch_count + LIMIT_W'(1);
  assign sh_shift = {shift_reg[BYTE_BITS-2:0], 1'b0};

  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    shift_reg_next     = shift_reg;
    pause_count_next   = pause_count;
    stretch_count_next = stretch_count;
    ack_to_send_next   = ack_to_send;
    ack_flag_next      = ack_flag;
    sda_drive_next     = sda_drive;
    scl_drive_next     = scl_drive;
    rd_hold_next       = rd_hold;
    done               = 1'b0;
    go                 = 1'b0;
    ent_go             = 1'b0;
    ent_done           = 1'b0;
    ent                = PH_IDLE;

    if (phase == PH_IDLE) begin
      unique case (item.op)
        OP_START: begin
          sda_drive_next = 1'b0;
          ent            = PH_STA_STR;
          ent_go         = 1'b1;
        end
        OP_STOP: begin
          sda_drive_next = 1'b1;
          ent            = PH_STO_SETUP;
          ent_go         = 1'b1;
        end
        OP_WRITE: begin
          shift_reg_next = item.wr_data;
          bit_count_next = '0;
          sda_drive_next = !item.wr_data[BYTE_BITS-1];
          ent            = PH_WR_SETUP;
          ent_go         = 1'b1;
        end
        OP_READ: begin
          shift_reg_next   = '0;
          bit_count_next   = '0;
          ack_to_send_next = item.rd_ack;
          sda_drive_next   = 1'b0;
          ent              = PH_RD_SETUP;
          ent_go           = 1'b1;
        end
        default: ;
      endcase
    end else begin
      unique case (wait_kind(phase))
        WK_PAUSE: begin
          if (pause_count <= PAUSE_BITS'(1)) begin
            pause_count_next = '0;
            go               = 1'b1;
          end else begin
            pause_count_next = pause_count - PAUSE_BITS'(1);
          end
        end
        WK_STRETCH: begin
          if (item.scl) begin
            go = 1'b1;
          end else begin
            stretch_count_next = sc_inc;
            if (sc_inc >= cfg.stretch_limit) begin
              go = 1'b1;
            end
          end
        end
        default: go = 1'b1;
      endcase

      if (go) begin
        ent_go = 1'b1;
        unique case (phase)
          PH_STA_STR: ent = PH_STA_SDA;
          PH_STA_SDA: begin
            sda_drive_next = 1'b1;
            ent            = PH_STA_SCL;
          end
          PH_STA_SCL: begin
            scl_drive_next = 1'b1;
            ent_done       = 1'b1;
          end
          PH_STO_SETUP: ent = PH_STO_STR;
          PH_STO_STR:   ent = PH_STO_SDA;
          PH_STO_SDA: begin
            sda_drive_next = 1'b0;
            ent            = PH_STO_HOLD;
          end
          PH_STO_HOLD: ent_done = 1'b1;
          PH_WR_SETUP: ent = PH_WR_STR;
          PH_WR_STR:   ent = PH_WR_HIGH;
          PH_WR_HIGH: begin
            scl_drive_next = 1'b1;
            shift_reg_next = sh_shift;
            bit_count_next = bc_inc;
            if (bc_inc < 4'(BYTE_BITS)) begin
              sda_drive_next = !sh_shift[BYTE_BITS-1];
              ent            = PH_WR_SETUP;
            end else begin
              sda_drive_next = 1'b0;
              ent            = PH_WA_SETUP;
            end
          end
          PH_WA_SETUP: ent = PH_WA_STR;
          PH_WA_STR:   ent = PH_WA_HIGH;
          PH_WA_HIGH: begin
            ack_flag_next  = !item.sda;
            scl_drive_next = 1'b1;
            ent            = PH_WA_HOLD;
          end
          PH_WA_HOLD:  ent_done = 1'b1;
          PH_RD_SETUP: ent = PH_RD_STR;
          PH_RD_STR:   ent = PH_RD_HIGH;
          PH_RD_HIGH: begin
            shift_reg_next = {shift_reg[BYTE_BITS-2:0], item.sda};
            scl_drive_next = 1'b1;
            bit_count_next = bc_inc;
            if (bc_inc < 4'(BYTE_BITS)) begin
              ent = PH_RD_SETUP;
            end else begin
              sda_drive_next = ack_to_send;
              ent            = PH_RA_SETUP;
            end
          end
          PH_RA_SETUP: ent = PH_RA_STR;
          PH_RA_STR:   ent = PH_RA_HIGH;
          PH_RA_HIGH: begin
            scl_drive_next = 1'b1;
            sda_drive_next = 1'b0;
            ent            = PH_RA_HOLD;
          end
          PH_RA_HOLD: begin
            rd_hold_next = shift_reg;
            ent_done     = 1'b1;
          end
          default: ent_done = 1'b1;
        endcase
      end
    end

    // Enter the next phase; a stretch wait with no limit falls through to its pause
    if (ent_done) begin
      phase_next = PH_IDLE;
      done       = 1'b1;
    end else if (ent_go) begin
      if (wait_kind(ent) == WK_STRETCH) begin
        scl_drive_next     = 1'b0;
        stretch_count_next = '0;
        if (cfg.stretch_limit != '0) begin
          phase_next = ent;
        end else begin
          phase_next       = phase_t'(ent + 5'd1);
          pause_count_next = pause_load;
        end
      end else begin
        phase_next       = ent;
        pause_count_next = pause_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= '0;
      shift_reg     <= '0;
      pause_count   <= '0;
      stretch_count <= '0;
      ack_to_send   <= 1'b0;
      ack_flag      <= 1'b0;
      sda_drive     <= 1'b0;
      scl_drive     <= 1'b0;
      rd_hold       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (fire) begin
        phase         <= phase_next;
        bit_count     <= bit_count_next;
        shift_reg     <= shift_reg_next;
        pause_count   <= pause_count_next;
        stretch_count <= stretch_count_next;
        ack_to_send   <= ack_to_send_next;
        ack_flag      <= ack_flag_next;
        sda_drive     <= sda_drive_next;
        scl_drive     <= scl_drive_next;
        rd_hold       <= rd_hold_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register: loaded with the state left by each item
  always_ff @(posedge clk) begin
    if (fire) begin
      sda_low   <= sda_drive_next;
      scl_low   <= scl_drive_next;
      busy_res  <= (phase_next != PH_IDLE);
      done_res  <= done;
      ack_seen  <= ack_flag_next;
      read_byte <= rd_hold_next;
    end
  end

endmodule

// ===== rtl/i2c_master_byte_engine_core.sv =====
// I2C master bit engine for open-drain lines. While idle, an item carrying a
// start, stop, write-byte or read-byte command launches that sequence; every
// later item is a tick that advances the SDA/SCL drive outputs by one step
// (pauses of half_period ticks, SCL stretch waits of up to stretch_limit
// ticks). Each item yields exactly one result with the line drives, busy,
// done, the last write ACK and the last read byte. The engine takes one item
// per clock while its result is not stalled: each item is one state update in
// the back-end sequencer, fed through a two-entry queue, and the result lands
// in an output register when the sequencer takes the item from the queue.
// Input stalls only when the queue holds two items behind a stalled result.
// Configuration writes are taken at any time but belong to idle periods.
module i2c_master_byte_engine_core #(
  parameter int PAUSE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      cmd,
  input  logic [i2cm_pkg::BYTE_BITS-1:0]   wr_data,
  input  logic                            rd_ack,
  input  logic                            sda_in,
  input  logic                            scl_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            sda_low,
  output logic                            scl_low,
  output logic                            busy_res,
  output logic                            done_res,
  output logic                            ack_seen,
  output logic [i2cm_pkg::BYTE_BITS-1:0]   read_byte,
  input  logic                            cfg_we,
  input  logic [i2cm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2cm_pkg::*;

  cfg_t  cfg;
  item_t push_item;
  item_t q_item;
  logic  push;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period   <= HALF_PERIOD_RST;
      cfg.stretch_limit <= STRETCH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_PERIOD:   cfg.half_period   <= cfg_data[HALF_W-1:0];
        REG_STRETCH_LIMIT: cfg.stretch_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  i2cm_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .wr_data   (wr_data),
    .rd_ack    (rd_ack),
    .sda_in    (sda_in),
    .scl_in    (scl_in),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  i2cm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  i2cm_engine #(
    .PAUSE_BITS (PAUSE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .item      (q_item),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sda_low   (sda_low),
    .scl_low   (scl_low),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .ack_seen  (ack_seen),
    .read_byte (read_byte)
  );

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(done_res && busy_res))
    else $error("done reported while still busy");

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("engine popped an empty queue");

  a_result_from_queue: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(q_valid))
    else $error("result appeared without a queued item");

endmodule

// ===== dv/tb_i2c_master_byte_engine_core.sv =====
`timescale 1ns / 100ps

import i2cm_pkg::*;

// Command codes the engine does not know; ignored while idle
localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

typedef enum logic [4:0] {
  PH_IDLE     = 5'd0,
  PH_ST_SCL   = 5'd1,
  PH_ST_SDA   = 5'd2,
  PH_ST_HOLD  = 5'd3,
  PH_SP_LOW   = 5'd4,
  PH_SP_SCL   = 5'd5,
  PH_SP_SDA   = 5'd6,
  PH_SP_END   = 5'd7,
  PH_WR_SETUP = 5'd8,
  PH_WR_SCL   = 5'd9,
  PH_WR_HIGH  = 5'd10,
  PH_WA_LOW   = 5'd11,
  PH_WA_SCL   = 5'd12,
  PH_WA_HIGH  = 5'd13,
  PH_WA_END   = 5'd14,
  PH_RD_LOW   = 5'd15,
  PH_RD_SCL   = 5'd16,
  PH_RD_HIGH  = 5'd17,
  PH_RA_LOW   = 5'd18,
  PH_RA_SCL   = 5'd19,
  PH_RA_HIGH  = 5'd20,
  PH_RA_END   = 5'd21,
  PH_DONE     = 5'd31
} bus_phase_e;

typedef enum logic [1:0] {
  WAIT_NONE,
  WAIT_PAUSE,
  WAIT_STRETCH
} wait_kind_e;

typedef struct packed {
  logic                 sda_low;
  logic                 scl_low;
  logic                 busy;
  logic                 done;
  logic                 ack;
  logic [BYTE_BITS-1:0] rd_byte;
} line_result_t;

class i2c_line_scoreboard;
  logic [HALF_W-1:0]    half_period;
  logic [LIMIT_W-1:0]   stretch_limit;
  bus_phase_e           phase;
  logic [3:0]           bit_count;
  logic [BYTE_BITS-1:0] shift_reg;
  logic [HALF_W-1:0]    pause_count;
  logic [7:0]           stretch_count;
  logic                 ack_to_send;
  logic                 ack_flag;
  logic                 sda_drive;
  logic                 scl_drive;
  logic [BYTE_BITS-1:0] rd_hold;
  line_result_t         expected_lines[$];
  int                   n_errors;
  int                   n_results;

  function new();
    half_period   = HALF_PERIOD_RST;
    stretch_limit = STRETCH_LIMIT_RST;
    phase         = PH_IDLE;
    bit_count     = '0;
    shift_reg     = '0;
    pause_count   = '0;
    stretch_count = '0;
    ack_to_send   = 1'b0;
    ack_flag      = 1'b0;
    sda_drive     = 1'b0;
    scl_drive     = 1'b0;
    rd_hold       = '0;
    n_errors      = 0;
    n_results     = 0;
  endfunction

  function void set_config(logic [HALF_W-1:0] half, logic [LIMIT_W-1:0] limit);
    half_period   = half;
    stretch_limit = limit;
  endfunction

  function bit engine_busy();
    return phase != PH_IDLE;
  endfunction

  function int pending();
    return expected_lines.size();
  endfunction

  function wait_kind_e wait_of(bus_phase_e p);
    case (p)
      PH_ST_SCL, PH_SP_SCL, PH_WR_SCL, PH_WA_SCL, PH_RD_SCL, PH_RA_SCL: return WAIT_STRETCH;
      PH_IDLE, PH_DONE: return WAIT_NONE;
      default: return WAIT_PAUSE;
    endcase
  endfunction

  // Enter a phase; returns 1 when it has to wait for later ticks.
  function bit enter_phase(bus_phase_e p);
    phase = p;
    case (wait_of(p))
      WAIT_PAUSE: begin
        pause_count = (half_period == '0) ? HALF_W'(1) : half_period;
        return 1'b1;
      end
      WAIT_STRETCH: begin
        scl_drive     = 1'b0;
        stretch_count = '0;
        return stretch_limit != '0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Line actions once the wait of a phase is over; returns the next phase.
  function bus_phase_e leave_phase(bus_phase_e p, logic sda);
    case (p)
      PH_ST_SCL:   return PH_ST_SDA;
      PH_ST_SDA: begin
        sda_drive = 1'b1;
        return PH_ST_HOLD;
      end
      PH_ST_HOLD: begin
        scl_drive = 1'b1;
        return PH_DONE;
      end
      PH_SP_LOW:   return PH_SP_SCL;
      PH_SP_SCL:   return PH_SP_SDA;
      PH_SP_SDA: begin
        sda_drive = 1'b0;
        return PH_SP_END;
      end
      PH_SP_END:   return PH_DONE;
      PH_WR_SETUP: return PH_WR_SCL;
      PH_WR_SCL:   return PH_WR_HIGH;
      PH_WR_HIGH: begin
        scl_drive = 1'b1;
        shift_reg = shift_reg << 1;
        bit_count = bit_count + 4'd1;
        if (bit_count < 4'd8) begin
          sda_drive = ~shift_reg[7];
          return PH_WR_SETUP;
        end
        sda_drive = 1'b0;
        return PH_WA_LOW;
      end
      PH_WA_LOW:   return PH_WA_SCL;
      PH_WA_SCL:   return PH_WA_HIGH;
      PH_WA_HIGH: begin
        ack_flag  = ~sda;
        scl_drive = 1'b1;
        return PH_WA_END;
      end
      PH_WA_END:   return PH_DONE;
      PH_RD_LOW:   return PH_RD_SCL;
      PH_RD_SCL:   return PH_RD_HIGH;
      PH_RD_HIGH: begin
        shift_reg = {shift_reg[6:0], sda};
        scl_drive = 1'b1;
        bit_count = bit_count + 4'd1;
        if (bit_count < 4'd8) return PH_RD_LOW;
        sda_drive = ack_to_send;
        return PH_RA_LOW;
      end
      PH_RA_LOW:   return PH_RA_SCL;
      PH_RA_SCL:   return PH_RA_HIGH;
      PH_RA_HIGH: begin
        scl_drive = 1'b1;
        sda_drive = 1'b0;
        return PH_RA_END;
      end
      PH_RA_END: begin
        rd_hold = shift_reg;
        return PH_DONE;
      end
      default:     return PH_DONE;
    endcase
  endfunction

  // Walk phases until one waits; returns 1 when the command completes.
  function bit advance_phases(bus_phase_e p, logic sda);
    while (p != PH_DONE) begin
      if (enter_phase(p)) return 1'b0;
      p = leave_phase(p, sda);
    end
    phase = PH_IDLE;
    return 1'b1;
  endfunction

  function void note_item(logic [2:0] c, logic [BYTE_BITS-1:0] wr, logic sack,
                          logic sda, logic scl);
    logic         done;
    logic         go;
    line_result_t want;
    done = 1'b0;
    go   = 1'b0;
    if (phase == PH_IDLE) begin
      case (c)
        CMD_START: begin
          sda_drive = 1'b0;
          done = advance_phases(PH_ST_SCL, sda);
        end
        CMD_STOP: begin
          sda_drive = 1'b1;
          done = advance_phases(PH_SP_LOW, sda);
        end
        CMD_WRITE: begin
          shift_reg = wr;
          bit_count = '0;
          sda_drive = ~wr[7];
          done = advance_phases(PH_WR_SETUP, sda);
        end
        CMD_READ: begin
          shift_reg   = '0;
          bit_count   = '0;
          ack_to_send = sack;
          sda_drive   = 1'b0;
          done = advance_phases(PH_RD_LOW, sda);
        end
        default: ;
      endcase
    end else begin
      case (wait_of(phase))
        WAIT_PAUSE: begin
          if (pause_count <= HALF_W'(1)) begin
            pause_count = '0;
            go = 1'b1;
          end else begin
            pause_count = pause_count - HALF_W'(1);
          end
        end
        WAIT_STRETCH: begin
          if (scl) begin
            go = 1'b1;
          end else begin
            stretch_count = stretch_count + 8'd1;
            if (stretch_count >= stretch_limit) go = 1'b1;
          end
        end
        default: go = 1'b1;
      endcase
      if (go) done = advance_phases(leave_phase(phase, sda), sda);
    end
    want.sda_low = sda_drive;
    want.scl_low = scl_drive;
    want.busy    = (phase != PH_IDLE);
    want.done    = done;
    want.ack     = ack_flag;
    want.rd_byte = rd_hold;
    expected_lines.push_back(want);
  endfunction

  task report_mismatch(string what, int got, int want);
    n_errors++;
    if (n_errors <= 40)
      $display("result %0d: %s got %0h, expected %0h", n_results, what, got, want);
  endtask

  task check_result(line_result_t got);
    line_result_t want;
    if (expected_lines.size() == 0) begin
      report_mismatch("unexpected result, sda_low", got.sda_low, 0);
    end else begin
      want = expected_lines.pop_front();
      if (got.sda_low !== want.sda_low) report_mismatch("sda_low", got.sda_low, want.sda_low);
      if (got.scl_low !== want.scl_low) report_mismatch("scl_low", got.scl_low, want.scl_low);
      if (got.busy !== want.busy) report_mismatch("busy_res", got.busy, want.busy);
      if (got.done !== want.done) report_mismatch("done_res", got.done, want.done);
      if (got.ack !== want.ack) report_mismatch("ack_seen", got.ack, want.ack);
      if (got.rd_byte !== want.rd_byte) report_mismatch("read_byte", got.rd_byte, want.rd_byte);
    end
    n_results++;
  endtask
endclass

module tb_i2c_master_byte_engine_core;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TOTAL_ITEMS    = 950;
  localparam int PHASE_ITEMS    = 160;
  localparam int MAX_GAP        = 17;

  typedef enum int {
    SDA_LOW,
    SDA_HIGH,
    SDA_RANDOM
  } sda_mode_e;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic [2:0]             cmd       = CMD_TICK;
  logic [BYTE_BITS-1:0]   wr_data   = '0;
  logic                   rd_ack    = 1'b0;
  logic                   sda_in    = 1'b1;
  logic                   scl_in    = 1'b1;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   sda_low;
  logic                   scl_low;
  logic                   busy_res;
  logic                   done_res;
  logic                   ack_seen;
  logic [BYTE_BITS-1:0]   read_byte;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_HALF_PERIOD;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  i2c_line_scoreboard sb;
  bit tx_calm    = 1'b0;
  int items_taken = 0;

  i2c_master_byte_engine_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic line_level(sda_mode_e mode);
    if (mode == SDA_RANDOM) return logic'($urandom_range(0, 1));
    return (mode == SDA_HIGH);
  endfunction

  task automatic send_item(logic [2:0] c, logic [BYTE_BITS-1:0] wr, logic sack,
                           logic sda, logic scl);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    wr_data  <= wr;
    rd_ack   <= sack;
    sda_in   <= sda;
    scl_in   <= scl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(c, wr, sack, sda, scl);
    items_taken++;
  endtask

  // Tick until the engine goes idle; scl_in is low with the given percentage.
  task automatic tick_until_idle(int low_pct, sda_mode_e sda_mode, bit noisy);
    logic [2:0] c;
    while (sb.engine_busy()) begin
      c = (noisy && $urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : CMD_TICK;
      send_item(c, BYTE_BITS'($urandom), logic'($urandom_range(0, 1)),
                line_level(sda_mode), $urandom_range(1, 100) > low_pct);
    end
  endtask

  task automatic run_cmd(logic [2:0] c, logic [BYTE_BITS-1:0] wr, logic sack,
                         int low_pct, sda_mode_e sda_mode, bit noisy);
    send_item(c, wr, sack, line_level(sda_mode), $urandom_range(1, 100) > low_pct);
    tick_until_idle(low_pct, sda_mode, noisy);
  endtask

  // Drop valid and wait for every outstanding result plus the pipeline depth.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(logic [HALF_W-1:0] half, logic [LIMIT_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HALF_PERIOD;
    cfg_data  <= CFG_DATA_W'(half);
    sb.set_config(half, limit);
    @(posedge clk);
    cfg_index <= REG_STRETCH_LIMIT;
    // upper bits are beyond the register width and must be dropped
    cfg_data  <= CFG_DATA_W'({$urandom(), limit});
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: random stalls, with stretches of steady acceptance.
  initial begin
    int gap;
    bit calm;
    line_result_t got;
    calm = 1'b0;
    wait (rst == 1'b0);
    forever begin
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.sda_low = sda_low;
      got.scl_low = scl_low;
      got.busy    = busy_res;
      got.done    = done_res;
      got.ack     = ack_seen;
      got.rd_byte = read_byte;
      sb.check_result(got);
      if ($urandom_range(0, 99) < 3) calm = !calm;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [HALF_W-1:0]  half;
    logic [LIMIT_W-1:0] limit;
    int                 low_pct;
    int                 phase_goal;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: full pauses, stretch waits under the full limit
    run_cmd(CMD_START, 8'h00, 1'b0, 20, SDA_RANDOM, 1'b0);
    settle();

    set_config(16'd1, 8'd3);
    send_item(CMD_TICK, 8'h5A, 1'b1, 1'b0, 1'b0);
    for (int k = CMD_UNUSED_LO; k <= CMD_UNUSED_HI; k++)
      send_item(3'(k), BYTE_BITS'($urandom), 1'b1, 1'b0, 1'b1);
    run_cmd(CMD_START, 8'h00, 1'b0, 100, SDA_RANDOM, 1'b0);
    run_cmd(CMD_WRITE, 8'hFF, 1'b0, 0, SDA_HIGH, 1'b0);
    run_cmd(CMD_WRITE, 8'h00, 1'b0, 0, SDA_LOW, 1'b0);
    run_cmd(CMD_WRITE, 8'hA5, 1'b1, 30, SDA_RANDOM, 1'b0);
    run_cmd(CMD_READ, 8'h00, 1'b1, 0, SDA_HIGH, 1'b0);
    run_cmd(CMD_READ, 8'hFF, 1'b0, 0, SDA_LOW, 1'b0);
    // commands arriving mid-sequence only count as ticks
    run_cmd(CMD_WRITE, 8'h3C, 1'b0, 20, SDA_RANDOM, 1'b1);
    run_cmd(CMD_READ, 8'h00, 1'b1, 20, SDA_RANDOM, 1'b1);
    run_cmd(CMD_STOP, 8'h00, 1'b0, 0, SDA_RANDOM, 1'b0);
    settle();

    set_config(16'd0, 8'd0);
    run_cmd(CMD_START, 8'h00, 1'b0, 50, SDA_RANDOM, 1'b0);
    run_cmd(CMD_WRITE, 8'h81, 1'b0, 50, SDA_RANDOM, 1'b0);
    run_cmd(CMD_READ, 8'h00, 1'b1, 50, SDA_RANDOM, 1'b0);
    run_cmd(CMD_STOP, 8'h00, 1'b0, 50, SDA_RANDOM, 1'b0);
    settle();

    while (items_taken < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: half = HALF_W'($urandom_range(0, 2));
        5, 6, 7:       half = HALF_W'($urandom_range(3, 8));
        default:       half = 16'd1;
      endcase
      case ($urandom_range(0, 3))
        0:       limit = 8'd0;
        1:       limit = 8'd1;
        2:       limit = LIMIT_W'($urandom_range(2, 20));
        default: limit = 8'd255;
      endcase
      set_config(half, limit);
      phase_goal = items_taken + PHASE_ITEMS;
      while (items_taken < phase_goal && items_taken < TOTAL_ITEMS) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
          0:       low_pct = 0;
          1:       low_pct = 20;
          2:       low_pct = 60;
          default: low_pct = 95;
        endcase
        if ($urandom_range(0, 99) < 15) begin
          repeat ($urandom_range(1, 3))
            send_item($urandom_range(0, 1) ? CMD_TICK :
                      3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                      BYTE_BITS'($urandom), logic'($urandom_range(0, 1)),
                      logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
        end else begin
          run_cmd(3'($urandom_range(CMD_START, CMD_READ)), BYTE_BITS'($urandom),
                  logic'($urandom_range(0, 1)), low_pct, SDA_RANDOM,
                  $urandom_range(0, 3) == 0);
        end
      end
      tx_calm = 1'b0;
      settle();
    end

    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
